### hdl/ppd_pkg.sv
// ----------------------------------------------------------------------------
// ppd_pkg
// shared types, register indexes and widths of the ppm pulse train decoder
// ----------------------------------------------------------------------------
package ppd_pkg;

  localparam int MAX_CHANNELS_DEF = 16;

  localparam int TIME_W   = 32;
  localparam int VAL_W    = 16;
  localparam int CNT_W    = 5;
  localparam int CHAN_W   = 8;
  localparam int KIND_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 72;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLANK_TIME    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_VALUE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VALUE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE     = 3'd4;

  typedef enum logic [KIND_W-1:0] {
    KIND_EDGE  = 2'd0,
    KIND_RAW   = 2'd1,
    KIND_VALID = 2'd2
  } kind_t;

  typedef struct packed {
    logic [CNT_W-1:0] channel_count;
    logic [VAL_W-1:0] blank_time;
    logic [VAL_W-1:0] min_value;
    logic [VAL_W-1:0] max_value;
    logic [VAL_W-1:0] tolerance;
  } cfg_t;

  typedef struct packed {
    logic              frame_start;
    logic              slot_written;
    logic              value_accepted;
    logic [TIME_W-1:0] interval_us;
  } edge_res_t;

  typedef struct packed {
    logic             raw_we;
    logic             valid_we;
    logic [CNT_W-1:0] idx;
    logic [VAL_W-1:0] raw_data;
    logic [VAL_W-1:0] valid_data;
  } slot_wr_t;

endpackage

### hdl/ppd_cfg_regs.sv
// ----------------------------------------------------------------------------
// ppd_cfg_regs
// configuration register file, written by index
// ----------------------------------------------------------------------------
module ppd_cfg_regs import ppd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_idx,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.channel_count <= CNT_W'(8);
      cfg_r.blank_time    <= VAL_W'(2100);
      cfg_r.min_value     <= VAL_W'(1000);
      cfg_r.max_value     <= VAL_W'(2000);
      cfg_r.tolerance     <= VAL_W'(10);
    end else if (wr_en) begin
      unique case (wr_idx)
        REG_CHANNEL_COUNT: cfg_r.channel_count <= wr_data[CNT_W-1:0];
        REG_BLANK_TIME:    cfg_r.blank_time    <= wr_data;
        REG_MIN_VALUE:     cfg_r.min_value     <= wr_data;
        REG_MAX_VALUE:     cfg_r.max_value     <= wr_data;
        REG_TOLERANCE:     cfg_r.tolerance     <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### hdl/ppd_store.sv
// ----------------------------------------------------------------------------
// ppd_store
// one slot memory with per-entry valid bits; unwritten entries read as zero
// ----------------------------------------------------------------------------
module ppd_store import ppd_pkg::*; #(
  parameter int DEPTH = MAX_CHANNELS_DEF,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [VAL_W-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [VAL_W-1:0] rd_data
);

  logic [VAL_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [VAL_W-1:0] rdata_r;
  logic             rvld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rvld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rvld_r ? rdata_r : '0;

endmodule

### hdl/ppd_edge_unit.sv
// ----------------------------------------------------------------------------
// ppd_edge_unit
// edge interval, frame gap detection, slot counter, tolerance window and min/max clamp
// ----------------------------------------------------------------------------
module ppd_edge_unit import ppd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic [CNT_W-1:0]  n_eff,
  input  logic              edge_en,
  input  logic [TIME_W-1:0] edge_time,
  output edge_res_t         res,
  output slot_wr_t          wr
);

  logic [TIME_W-1:0] last_r;
  logic [CNT_W-1:0]  slot_r;

  logic [TIME_W-1:0] interval;
  logic              frame;
  logic              room;
  logic              in_win;
  logic [VAL_W-1:0]  lo;
  logic [VAL_W:0]    hi;
  logic [VAL_W-1:0]  clamped;

  always_comb begin
    interval = edge_time - last_r;
    frame    = interval > {16'd0, cfg.blank_time};
    room     = slot_r < n_eff;
    lo       = (cfg.tolerance > cfg.min_value) ? '0 : cfg.min_value - cfg.tolerance;
    hi       = {1'b0, cfg.max_value} + {1'b0, cfg.tolerance};
    in_win   = (interval >= {16'd0, lo}) && (interval <= {15'd0, hi});
    if (interval < {16'd0, cfg.min_value}) begin
      clamped = cfg.min_value;
    end else if (interval > {16'd0, cfg.max_value}) begin
      clamped = cfg.max_value;
    end else begin
      clamped = interval[VAL_W-1:0];
    end

    res.frame_start    = frame;
    res.slot_written   = !frame && room;
    res.value_accepted = !frame && room && in_win;
    res.interval_us    = interval;

    wr.raw_we     = edge_en && res.slot_written;
    wr.valid_we   = edge_en && res.value_accepted;
    wr.idx        = slot_r;
    wr.raw_data   = interval[VAL_W-1:0];
    wr.valid_data = clamped;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
      slot_r <= '0;
    end else if (edge_en) begin
      last_r <= edge_time;
      if (frame) begin
        slot_r <= '0;
      end else if (room) begin
        slot_r <= slot_r + CNT_W'(1);
      end
    end
  end

endmodule

### hdl/ppm_pulse_train_decoder.sv
// ----------------------------------------------------------------------------
// ppm_pulse_train_decoder
// decodes a radio-control ppm pulse train into per-channel slot values
// ----------------------------------------------------------------------------
//  channel | direction | contents
//  in_     | slave     | edge timestamp or channel read request, kind in tuser
//  out_    | master    | one result word per input word
//  cfg_    | slave     | register index and write data, always ready
//
//  one word is accepted per cycle while in_tready is high; a result word passes
//  the memory read stage, then the output register, since the slot memories
//  are read synchronously
//  reset clears timing state and per-entry valid bits, sets config defaults; no
//  clearing pass is needed, unwritten entries read as zero
//  a stalled output holds the result; the middle stage fills and then in_tready
//  drops until out_tready returns
// ----------------------------------------------------------------------------
module ppm_pulse_train_decoder import ppd_pkg::*; #(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input words
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [31:0] edge_time_us, [39:32] channel, [71:40] default_value
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [1:0] kind
  input  logic [KIND_W-1:0]     in_tuser,
  // result words
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [31:0] read_value, [32] channel_ok, [33] frame_start, [34] slot_written,
  // [35] value_accepted, [67:36] interval_us, [71:68] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // slot address width, at least one bit
  localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  cfg_t cfg;

  // input word fields
  kind_t             in_kind;
  logic [TIME_W-1:0] in_time;
  logic [CHAN_W-1:0] in_chan;
  logic [TIME_W-1:0] in_dflt;
  logic              in_acc;
  logic              edge_en;
  logic              rd_en;

  // effective channel count and read channel check
  logic [CNT_W-1:0]  n_eff;
  logic              chan_ok;
  logic [CHAN_W-1:0] chan_m1;

  edge_res_t         edge_res;
  slot_wr_t          slot_wr;
  logic [VAL_W-1:0]  raw_rd;
  logic [VAL_W-1:0]  valid_rd;

  // middle stage: memory data arrives here
  logic              s1_vld_r;
  logic [KIND_W-1:0] s1_kind_r;
  logic              s1_ok_r;
  logic [TIME_W-1:0] s1_dflt_r;
  edge_res_t         s1_edge_r;
  logic              s1_go;

  // output register
  logic                  out_vld_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_DATA_W-1:0] out_data_nxt;

  logic [TIME_W-1:0] rd_value;
  logic              rd_ok;

  assign cfg_ready = 1'b1;

  ppd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  assign in_kind = kind_t'(in_tuser);
  assign in_time = in_tdata[31:0];
  assign in_chan = in_tdata[39:32];
  assign in_dflt = in_tdata[71:40];

  // output stage frees up when empty or being drained
  assign s1_go     = !out_vld_r || out_tready;
  assign in_tready = !s1_vld_r || s1_go;
  assign in_acc    = in_tvalid && in_tready;
  assign edge_en   = in_acc && (in_kind == KIND_EDGE);
  assign rd_en     = in_acc && ((in_kind == KIND_RAW) || (in_kind == KIND_VALID));

  // channel count limited to the store depth
  always_comb begin
    if ({1'b0, cfg.channel_count} > 6'(MAX_CHANNELS)) begin
      n_eff = CNT_W'(MAX_CHANNELS);
    end else begin
      n_eff = cfg.channel_count;
    end
  end

  assign chan_ok = (in_chan != '0) && (in_chan <= {3'd0, n_eff});
  assign chan_m1 = in_chan - CHAN_W'(1);

  ppd_edge_unit u_edge (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .n_eff     (n_eff),
    .edge_en   (edge_en),
    .edge_time (in_time),
    .res       (edge_res),
    .wr        (slot_wr)
  );

  // writes land at accept, so a read in the next cycle already sees them
  ppd_store #(
    .DEPTH (MAX_CHANNELS),
    .AW    (AW)
  ) u_raw_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (slot_wr.raw_we),
    .wr_addr (slot_wr.idx[AW-1:0]),
    .wr_data (slot_wr.raw_data),
    .rd_en   (rd_en && chan_ok),
    .rd_addr (chan_m1[AW-1:0]),
    .rd_data (raw_rd)
  );

  ppd_store #(
    .DEPTH (MAX_CHANNELS),
    .AW    (AW)
  ) u_valid_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (slot_wr.valid_we),
    .wr_addr (slot_wr.idx[AW-1:0]),
    .wr_data (slot_wr.valid_data),
    .rd_en   (rd_en && chan_ok),
    .rd_addr (chan_m1[AW-1:0]),
    .rd_data (valid_rd)
  );

  // middle stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_kind_r <= in_tuser;
      s1_ok_r   <= chan_ok;
      s1_dflt_r <= in_dflt;
      s1_edge_r <= edge_en ? edge_res : '0;
    end
  end

  // result word assembly
  always_comb begin
    rd_value = '0;
    rd_ok    = 1'b0;
    unique case (s1_kind_r)
      KIND_RAW: begin
        rd_ok    = s1_ok_r;
        rd_value = s1_ok_r ? {16'd0, raw_rd} : '0;
      end
      KIND_VALID: begin
        rd_ok    = s1_ok_r;
        rd_value = s1_ok_r ? {16'd0, valid_rd} : s1_dflt_r;
      end
      default: ;
    endcase
    out_data_nxt = {4'd0, s1_edge_r.interval_us, s1_edge_r.value_accepted,
                    s1_edge_r.slot_written, s1_edge_r.frame_start, rd_ok, rd_value};
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_go) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_vld_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

### dv/tb_ppm_pulse_train_decoder.sv
// ----------------------------------------------------------------------------
// tb_ppm_pulse_train_decoder
// self-checking bench for the ppm pulse train decoder: a directed table of
// edge and read words after reset, then frame-shaped random traffic under a
// series of register settings, every result word matched against a typed row or a local
// decoder model
// ----------------------------------------------------------------------------
module tb_ppm_pulse_train_decoder import ppd_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // kind code the block must ignore
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam int WORDS_PER_PHASE = 150;

  // one result word split into its fields
  typedef struct packed {
    logic [31:0] read_value;
    logic        channel_ok;
    logic        frame_start;
    logic        slot_written;
    logic        value_accepted;
    logic [31:0] interval_us;
  } outcome_t;

  // one input word plus an optional hand-written expectation
  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [31:0]       stamp;
    logic [7:0]        channel;
    logic [31:0]       fallback;
    bit                typed;
    outcome_t          want;
  } probe_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // [31:0] edge_time_us, [39:32] channel, [71:40] default_value
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  // [1:0] kind
  logic [KIND_W-1:0]     in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // [31:0] read_value, [32] channel_ok, [33] frame_start, [34] slot_written,
  // [35] value_accepted, [67:36] interval_us, [71:68] zero
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  ppm_pulse_train_decoder uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // hard stop in case the block hangs
  initial begin
    #4_000_000;
    $display("tb_ppm_pulse_train_decoder: errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // decoder model: its own copy of registers, slot counter and both stores
  // ---------------------------------------------------------------------------
  cfg_t        model_cfg;
  logic [31:0] model_last_edge;
  logic [4:0]  model_slot;
  logic [15:0] raw_mirror   [MAX_CHANNELS_DEF];
  logic [15:0] valid_mirror [MAX_CHANNELS_DEF];

  probe_t   sent_words [$];
  outcome_t pending_results [$];

  int  err_count = 0;
  bit  calm = 1'b0;
  logic [31:0] gen_time = '0;

  // computes the result word of one input word and advances the model
  function automatic outcome_t decode_word(logic [KIND_W-1:0] kind, logic [31:0] stamp,
                                           logic [7:0] channel, logic [31:0] fallback);
    outcome_t    o;
    logic [4:0]  lim;
    logic [31:0] span, lo, hi, v;
    o = '0;
    // counts above the store depth act as the full depth
    lim = (model_cfg.channel_count > MAX_CHANNELS_DEF) ? 5'(MAX_CHANNELS_DEF)
                                                        : model_cfg.channel_count;
    if (kind == KIND_EDGE) begin
      span = stamp - model_last_edge;   // wraps modulo 2^32
      model_last_edge = stamp;
      o.interval_us = span;
      if (span > 32'(model_cfg.blank_time)) begin
        model_slot = '0;
        o.frame_start = 1'b1;
      end else if (model_slot < lim) begin
        // window: lower edge floors at zero, upper edge widened past 16 bits
        lo = (model_cfg.tolerance > model_cfg.min_value) ? 32'd0
           : 32'(model_cfg.min_value - model_cfg.tolerance);
        hi = 32'(model_cfg.max_value) + 32'(model_cfg.tolerance);
        raw_mirror[model_slot] = span[15:0];
        o.slot_written = 1'b1;
        if (span >= lo && span <= hi) begin
          // when the bounds are crossed, spans below min take min and the rest take max
          v = span;
          if (v < 32'(model_cfg.min_value))
            v = 32'(model_cfg.min_value);
          else if (v > 32'(model_cfg.max_value))
            v = 32'(model_cfg.max_value);
          valid_mirror[model_slot] = v[15:0];
          o.value_accepted = 1'b1;
        end
        model_slot = model_slot + 5'd1;
      end
      // a full frame leaves the counter parked until the next gap
    end else if (kind == KIND_RAW || kind == KIND_VALID) begin
      o.channel_ok = (channel >= 8'd1 && channel <= 8'(lim));
      if (o.channel_ok)
        o.read_value = (kind == KIND_RAW) ? 32'(raw_mirror[channel - 8'd1])
                                          : 32'(valid_mirror[channel - 8'd1]);
      else
        o.read_value = (kind == KIND_RAW) ? 32'd0 : fallback;
    end
    return o;
  endfunction

  probe_t   taken;
  outcome_t predicted;

  // input side monitor: tracks register writes and accepted words
  always @(posedge clk) begin
    if (!rst_n) begin
      model_cfg = '{5'd8, 16'd2100, 16'd1000, 16'd2000, 16'd10};
      model_last_edge = '0;
      model_slot = '0;
      foreach (raw_mirror[i]) begin
        raw_mirror[i] = '0;
        valid_mirror[i] = '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CHANNEL_COUNT: model_cfg.channel_count = cfg_data[CNT_W-1:0];
          REG_BLANK_TIME:    model_cfg.blank_time = cfg_data;
          REG_MIN_VALUE:     model_cfg.min_value = cfg_data;
          REG_MAX_VALUE:     model_cfg.max_value = cfg_data;
          REG_TOLERANCE:     model_cfg.tolerance = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        taken = sent_words.pop_front();
        predicted = decode_word(in_tuser, in_tdata[31:0], in_tdata[39:32], in_tdata[71:40]);
        // hand-written rows override the model
        pending_results.push_back(taken.typed ? taken.want : predicted);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------
  task automatic flag_error(string msg);
    err_count++;
    if (err_count <= 60)
      $display("%0t ns: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      flag_error($sformatf("%s got %h want %h", name, got, want));
  endtask

  outcome_t seen, owed;

  // result side: each word matched against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen = '{out_tdata[31:0], out_tdata[32], out_tdata[33], out_tdata[34],
               out_tdata[35], out_tdata[67:36]};
      if (pending_results.size() == 0) begin
        flag_error($sformatf("result word %h with nothing expected", out_tdata));
      end else begin
        owed = pending_results.pop_front();
        check_field("read_value", seen.read_value, owed.read_value);
        check_field("channel_ok", 32'(seen.channel_ok), 32'(owed.channel_ok));
        check_field("frame_start", 32'(seen.frame_start), 32'(owed.frame_start));
        check_field("slot_written", 32'(seen.slot_written), 32'(owed.slot_written));
        check_field("value_accepted", 32'(seen.value_accepted), 32'(owed.value_accepted));
        check_field("interval_us", seen.interval_us, owed.interval_us);
      end
    end
  end

  // receiver drops ready at random with a 9 percent chance, never in the calm stretch
  always @(posedge clk)
    out_tready <= calm ? 1'b1 : ($urandom_range(99) >= 9);

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  // one input word: random gaps first, valid held high until taken
  task automatic send_word(logic [KIND_W-1:0] kind, logic [31:0] stamp, logic [7:0] channel,
                           logic [31:0] fallback, bit typed, outcome_t want);
    probe_t p;
    p = '{kind, stamp, channel, fallback, typed, want};
    while (!calm && $urandom_range(99) < 9) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    sent_words.push_back(p);
    if (kind == KIND_EDGE)
      gen_time = stamp;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {fallback, channel, stamp};
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
  endtask

  // drop valid and wait until every owed result word is back
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0)
      @(posedge clk);
    // two-stage pipe, plus margin
    repeat (4) @(posedge clk);
  endtask

  // all five registers back to back, valid held across the burst
  task automatic program_regs(cfg_t c);
    logic [CFG_IDX_W-1:0]  idx  [5];
    logic [CFG_DATA_W-1:0] vals [5];
    idx  = '{REG_CHANNEL_COUNT, REG_BLANK_TIME, REG_MIN_VALUE, REG_MAX_VALUE, REG_TOLERANCE};
    vals = '{16'(c.channel_count), c.blank_time, c.min_value, c.max_value, c.tolerance};
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready)
        @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // edge spacing aimed at the window edges, the blank threshold and beyond
  function automatic logic [31:0] pick_interval(cfg_t c);
    logic [31:0] lo, hi, a;
    int r;
    lo = (c.tolerance > c.min_value) ? 32'd0 : 32'(c.min_value - c.tolerance);
    hi = 32'(c.max_value) + 32'(c.tolerance);
    r = $urandom_range(99);
    if (r < 6)
      return 32'(c.blank_time) + 32'd1 + $urandom_range(20000);
    if (r < 8)
      return 32'(c.blank_time);
    if (r < 10)
      return 32'(c.blank_time) + 32'd1;
    if (r < 13)
      return $urandom;
    if (r < 25) begin
      case ($urandom_range(5))
        0: return lo;
        1: return (lo != 0) ? lo - 32'd1 : 32'd0;
        2: return hi;
        3: return hi + 32'd1;
        4: return 32'(c.min_value);
        default: return 32'(c.max_value);
      endcase
    end
    a = (lo > 32'd300) ? lo - 32'd300 : 32'd0;
    return $urandom_range(hi + 32'd300, a);
  endfunction

  // raw or valid read, now and then the unused kind
  task automatic send_read();
    logic [KIND_W-1:0] k;
    logic [7:0]        ch;
    int                r;
    r = $urandom_range(99);
    k = (r < 4) ? KIND_UNUSED : (r < 52) ? KIND_RAW : KIND_VALID;
    ch = ($urandom_range(99) < 85) ? 8'($urandom_range(17)) : 8'($urandom);
    send_word(k, $urandom, ch, $urandom, 1'b0, '0);
  endtask

  // frames: a gap edge, then about channel_count edges with reads in between;
  // some frames lose their gap or run long
  task automatic run_phase(cfg_t c, int quota);
    int         done;
    int         slots;
    logic [4:0] lim;
    done = 0;
    lim = (c.channel_count > MAX_CHANNELS_DEF) ? 5'(MAX_CHANNELS_DEF) : c.channel_count;
    while (done < quota) begin
      if ($urandom_range(99) >= 10) begin
        send_word(KIND_EDGE, gen_time + 32'(c.blank_time) + 32'd1 + $urandom_range(3000),
                  8'($urandom), $urandom, 1'b0, '0);
        done++;
      end
      slots = $urandom_range(int'(lim) + 2);
      for (int s = 0; s < slots; s++) begin
        while ($urandom_range(99) < 30) begin
          send_read();
          done++;
        end
        send_word(KIND_EDGE, gen_time + pick_interval(c), 8'($urandom), $urandom, 1'b0, '0);
        done++;
      end
    end
  endtask

  // directed words at reset settings (8 channels, blank 2100, 1000..2000, tol 10);
  // typed rows are reset reads, bad channels, the unused kind and the first edge
  probe_t dir_tab [24] = '{
    '{KIND_RAW,    32'd0, 8'd1, 32'd0, 1'b1, '{32'd0, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0}},
    '{KIND_VALID,  32'd0, 8'd8, 32'd0, 1'b1, '{32'd0, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0}},
    // bad channels: default on a valid read, zero on a raw read
    '{KIND_VALID,  32'd0, 8'd0, 32'hDEADBEEF, 1'b1,
      '{32'hDEADBEEF, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0}},
    '{KIND_RAW,    32'd0, 8'd9, 32'h12345678, 1'b1,
      '{32'd0, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0}},
    '{KIND_VALID,  32'hFFFFFFFF, 8'd255, 32'hFFFFFFFF, 1'b1,
      '{32'hFFFFFFFF, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0}},
    // unused kind with every bit set: all-zero result
    '{KIND_UNUSED, 32'hFFFFFFFF, 8'hFF, 32'hFFFFFFFF, 1'b1, '0},
    // first edge measured from timestamp zero
    '{KIND_EDGE,   32'd5000, 8'd0, 32'd0, 1'b1, '{32'd0, 1'b0, 1'b1, 1'b0, 1'b0, 32'd5000}},
    '{KIND_EDGE,   32'd6500,  8'd0, 32'd0, 1'b0, '0},   // 1500 in window
    '{KIND_EDGE,   32'd7490,  8'd0, 32'd0, 1'b0, '0},   // 990 lowest accepted
    '{KIND_EDGE,   32'd8479,  8'd0, 32'd0, 1'b0, '0},   // 989 raw only
    '{KIND_EDGE,   32'd10489, 8'd0, 32'd0, 1'b0, '0},   // 2010 highest accepted
    '{KIND_EDGE,   32'd12500, 8'd0, 32'd0, 1'b0, '0},   // 2011 raw only
    '{KIND_EDGE,   32'd14600, 8'd0, 32'd0, 1'b0, '0},   // exactly blank, still a slot
    '{KIND_EDGE,   32'd16701, 8'd0, 32'd0, 1'b0, '0},   // one past blank, new frame
    '{KIND_RAW,    32'd0, 8'd1, 32'd0, 1'b0, '0},
    '{KIND_VALID,  32'd0, 8'd2, 32'd0, 1'b0, '0},
    '{KIND_VALID,  32'd0, 8'd3, 32'd0, 1'b0, '0},
    '{KIND_VALID,  32'd0, 8'd4, 32'd0, 1'b0, '0},
    '{KIND_RAW,    32'd0, 8'd6, 32'd0, 1'b0, '0},
    '{KIND_EDGE,   32'hFFFFFF00, 8'd0, 32'd0, 1'b0, '0},
    '{KIND_EDGE,   32'h00000100, 8'd0, 32'd0, 1'b0, '0},   // wraps to 512
    '{KIND_EDGE,   32'h00000100, 8'd0, 32'd0, 1'b0, '0},   // zero interval
    '{KIND_EDGE,   32'hFFFFFFFF, 8'd0, 32'd0, 1'b0, '0},
    '{KIND_EDGE,   32'h000005DB, 8'd0, 32'd0, 1'b0, '0}    // wraps to 1500
  };

  // fixed settings: wide tolerance, one channel with all else zero, all-ones, zero
  // count with crossed bounds and tolerance above min, a narrow set, crossed bounds
  cfg_t phase_set [6] = '{
    '{5'd16, 16'd2100,  16'd1000,  16'd2000,  16'd500},
    '{5'd1,  16'd0,     16'd0,     16'd0,     16'd0},
    '{5'd31, 16'hFFFF,  16'hFFFF,  16'hFFFF,  16'hFFFF},
    '{5'd0,  16'd3000,  16'd1500,  16'd1200,  16'd2000},
    '{5'd4,  16'd2500,  16'd900,   16'd2100,  16'd100},
    '{5'd12, 16'd20000, 16'd5000,  16'd3000,  16'd0}
  };

  initial begin
    cfg_t rc;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i])
      send_word(dir_tab[i].kind, dir_tab[i].stamp, dir_tab[i].channel,
                dir_tab[i].fallback, dir_tab[i].typed, dir_tab[i].want);
    settle();

    // counter is left wherever a phase ended, so lowered counts see it parked
    foreach (phase_set[i]) begin
      program_regs(phase_set[i]);
      calm = (i == 2);
      run_phase(phase_set[i], WORDS_PER_PHASE);
      settle();
      calm = 1'b0;
    end
    for (int i = 0; i < 4; i++) begin
      rc.channel_count = 5'($urandom_range(16, 1));
      rc.blank_time    = 16'($urandom_range(30000, 1500));
      rc.min_value     = 16'($urandom_range(4000));
      rc.max_value     = 16'($urandom_range(6000));
      rc.tolerance     = 16'($urandom_range(int'(rc.min_value)));
      program_regs(rc);
      run_phase(rc, WORDS_PER_PHASE);
      settle();
    end

    repeat (6) @(posedge clk);
    if (err_count == 0 && pending_results.size() == 0)
      $display("tb_ppm_pulse_train_decoder: clean");
    else
      $display("tb_ppm_pulse_train_decoder: errors");
    $finish;
  end

endmodule

### files.f
hdl/ppd_pkg.sv
hdl/ppd_cfg_regs.sv
hdl/ppd_store.sv
hdl/ppd_edge_unit.sv
hdl/ppm_pulse_train_decoder.sv
dv/tb_ppm_pulse_train_decoder.sv
